@@ src/sliding_time_window_min_max_top_macros.svh @@
// Assertion macros for the sliding window min/max checker.
`ifndef SLIDING_TIME_WINDOW_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_TIME_WINDOW_MIN_MAX_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STWMM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stwmm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STWMM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stwmm: next-cycle check failed");

`endif

@@ src/stwmm_pkg.sv @@
// Shared constants, types and codes for the sliding window min/max block.
`timescale 1ns / 1ps

package stwmm_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int CNT_W       = $clog2(MAX_ENTRIES);

	localparam int TIME_W  = 24;
	localparam int AGE_W   = 27;
	localparam int WIN_W   = 26;
	localparam int WGT_W   = 17;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 40;

	localparam logic [AGE_W-1:0] AGE_MAX      = {AGE_W{1'b1}};
	localparam logic [WGT_W-1:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [WGT_W-1:0] WEIGHT_RESET = 17'd6554;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 26'd1000000;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd1;

	// One history entry as held by a cell
	typedef struct packed {
		logic              live;
		logic [AGE_W-1:0]  age;
		logic [TIME_W-1:0] dur;
	} entry_t;

	// Running min/max token passed down the cell row
	typedef struct packed {
		logic              any;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
	} minmax_t;

	// Strobes into the average unit
	typedef struct packed {
		logic mul;
		logic add;
	} ema_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

@@ src/stwmm_cell.sv @@
// One history cell: shifts in its neighbour's entry, ages it and folds it into the min/max token.
`timescale 1ns / 1ps

module stwmm_cell import stwmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [TIME_W-1:0] dur_in,
	input  logic [WIN_W-1:0]  window,
	input  entry_t            prev,
	input  minmax_t           tok_in,
	output entry_t            entry,
	output minmax_t           tok_out
);

	logic              live_q;
	logic [AGE_W-1:0]  age_q;
	logic [TIME_W-1:0] dur_q;
	minmax_t           tok_q;

	logic [AGE_W:0]   age_sum;
	logic [AGE_W-1:0] age_new;
	logic             live_new;
	minmax_t          tok_d;

	// saturating age update
	assign age_sum  = (AGE_W+1)'(prev.age) + (AGE_W+1)'(dur_in);
	assign age_new  = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
	assign live_new = prev.live && (age_new <= AGE_W'(window));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (shift) begin
			live_q <= live_new;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			age_q <= age_new;
			dur_q <= prev.dur;
		end
	end

	always_comb begin
		tok_d = tok_in;
		if (live_q) begin
			if (!tok_in.any) begin
				tok_d.any = 1'b1;
				tok_d.lo  = dur_q;
				tok_d.hi  = dur_q;
			end else begin
				if (dur_q < tok_in.lo) begin
					tok_d.lo = dur_q;
				end
				if (dur_q > tok_in.hi) begin
					tok_d.hi = dur_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	assign entry   = '{live: live_q, age: age_q, dur: dur_q};
	assign tok_out = tok_q;

endmodule

@@ src/stwmm_ema.sv @@
// Exponential moving average accumulator, Q24.16, two-step multiply then add.
`timescale 1ns / 1ps

module stwmm_ema import stwmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ema_ctl_t          ctl,
	input  logic [TIME_W-1:0] dur,
	input  logic [WGT_W-1:0]  weight,
	output logic [ACC_W-1:0]  acc
);

	localparam int PROD_A_W = ACC_W + WGT_W;
	localparam int PROD_B_W = TIME_W + WGT_W;

	logic [ACC_W-1:0]    acc_q;
	logic [PROD_A_W-1:0] prod_a_q;
	logic [PROD_B_W-1:0] prod_b_q;
	logic [WGT_W-1:0]    weight_inv;
	logic [ACC_W:0]      acc_sum;

	assign weight_inv = WEIGHT_ONE - weight;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_a_q <= PROD_A_W'(acc_q) * PROD_A_W'(weight_inv);
			prod_b_q <= PROD_B_W'(dur) * PROD_B_W'(weight);
		end
	end

	// (a + (b << 16)) >> 16 == (a >> 16) + b, as b << 16 has a clear low half
	assign acc_sum = (ACC_W+1)'(prod_a_q[PROD_A_W-1:FRAC_W]) + (ACC_W+1)'(prod_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= acc_sum[ACC_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

@@ src/sliding_time_window_min_max_top.sv @@
// Top level of the sliding time-window frame statistics block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------------
//  in       | in_valid / in_ready    | frame_time_us
//  out      | out_valid / out_ready  | average_us, window_min_us, window_max_us, window_empty
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item's result is loaded once the min/max token has walked the whole cell row, one cell
// a cycle, and the next item can be taken only after that load.
// in_ready is high only when idle; the finished result sits in the output register, so
// a new item is taken while the previous result still waits for out_ready.
// A stalled output only holds the last step until the output register frees up.
// Reset clears the live flags, the average and the control; no clearing pass.
// cfg_ready is always high; writes take effect in the next cycle.
`timescale 1ns / 1ps

module sliding_time_window_min_max_top import stwmm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TIME_W-1:0]     frame_time_us,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TIME_W-1:0]     average_us,
	output logic [TIME_W-1:0]     window_min_us,
	output logic [TIME_W-1:0]     window_max_us,
	output logic                  window_empty,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------
	logic [WGT_W-1:0] weight_q;
	logic [WIN_W-1:0] window_q;
	logic [WGT_W-1:0] weight_wr;

	assign cfg_ready = 1'b1;

	// gains above 1.0 saturate at write time
	assign weight_wr = (cfg_data[WGT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data[WGT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AVERAGE_WEIGHT: weight_q <= weight_wr;
				REG_WINDOW_LENGTH:  window_q <= cfg_data[WIN_W-1:0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------------------
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             in_xfer;
	logic             load_out;
	logic             out_valid_q;
	ema_ctl_t         ema_ctl;

	assign in_xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		ema_ctl  = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_RUN;
					cnt_d   = CNT_W'(MAX_ENTRIES - 1);
				end
			end
			ST_RUN: begin
				// average: multiply on the first run cycle, accumulate on the second
				ema_ctl.mul = (cnt_q == CNT_W'(MAX_ENTRIES - 1));
				ema_ctl.add = (cnt_q == CNT_W'(MAX_ENTRIES - 2));
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			ST_DONE: begin
				// tail token is settled; wait for a free output register
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------------------
	// Current duration, kept for the average and for the empty-window echo
	// ---------------------------------------------------------------------------------
	logic [TIME_W-1:0] dur_q;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dur_q <= frame_time_us;
		end
	end

	// ---------------------------------------------------------------------------------
	// Cell row: slot 0 newest; entries shift by one on every transfer, the min/max
	// token ripples down one cell per cycle
	// ---------------------------------------------------------------------------------
	entry_t  row_entry [MAX_ENTRIES];
	minmax_t row_tok   [MAX_ENTRIES+1];
	entry_t  head;

	assign head        = '{live: 1'b1, age: '0, dur: frame_time_us};
	assign row_tok[0]  = '{any: 1'b0, lo: '0, hi: '0};

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		stwmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (in_xfer),
			.dur_in  (frame_time_us),
			.window  (window_q),
			.prev    ((i == 0) ? head : row_entry[(i == 0) ? 0 : i-1]),
			.tok_in  (row_tok[i]),
			.entry   (row_entry[i]),
			.tok_out (row_tok[i+1])
		);
	end

	// ---------------------------------------------------------------------------------
	// Moving average
	// ---------------------------------------------------------------------------------
	logic [ACC_W-1:0] acc;

	stwmm_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ema_ctl),
		.dur    (dur_q),
		.weight (weight_q),
		.acc    (acc)
	);

	// ---------------------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------------------
	minmax_t           tail;
	logic [TIME_W-1:0] average_q;
	logic [TIME_W-1:0] min_q;
	logic [TIME_W-1:0] max_q;
	logic              empty_q;

	assign tail = row_tok[MAX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q <= acc[ACC_W-1:FRAC_W];
			min_q     <= tail.any ? tail.lo : dur_q;
			max_q     <= tail.any ? tail.hi : dur_q;
			empty_q   <= !tail.any;
		end
	end

	assign out_valid     = out_valid_q;
	assign average_us    = average_q;
	assign window_min_us = min_q;
	assign window_max_us = max_q;
	assign window_empty  = empty_q;

endmodule

@@ src/stwmm_checker.sv @@
// Port-level checks for the sliding window min/max block, bound to the top level.
`timescale 1ns / 1ps
`include "sliding_time_window_min_max_top_macros.svh"

module stwmm_checker import stwmm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [TIME_W-1:0]     average_us,
	input logic [TIME_W-1:0]     window_min_us,
	input logic [TIME_W-1:0]     window_max_us,
	input logic                  window_empty
);

	`STWMM_ASSERT_NOW(a_min_le_max, clk, arst_n, out_valid, window_min_us <= window_max_us)
	`STWMM_ASSERT_NOW(a_empty_echo, clk, arst_n, out_valid && window_empty, window_min_us == window_max_us)
	`STWMM_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	`STWMM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(average_us) && $stable(window_max_us))

endmodule

bind sliding_time_window_min_max_top stwmm_checker u_stwmm_checker (.*);

@@ tb/sliding_time_window_min_max_top_test.sv @@
// Self-checking testbench for the sliding time-window frame statistics block.
`timescale 1ns / 1ps

module sliding_time_window_min_max_top_test;
	import stwmm_pkg::*;

	// Every item yields one result.
	localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES;
	// Worst quiet spell: longest sender gap + block latency + longest receiver stall,
	// plus the settle pause between phases, taken several times over.
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_FRAMES = 1800;

	localparam logic [TIME_W-1:0]     TIME_TOP = {TIME_W{1'b1}};
	localparam logic [WIN_W-1:0]      WIN_TOP  = {WIN_W{1'b1}};
	localparam logic [CFG_DATA_W-1:0] DATA_TOP = {CFG_DATA_W{1'b1}};

	typedef struct packed {
		logic [TIME_W-1:0] avg_us;
		logic [TIME_W-1:0] min_us;
		logic [TIME_W-1:0] max_us;
		logic              none_live;
	} frame_stats_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [TIME_W-1:0]     frame_time_us = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TIME_W-1:0]     average_us;
	logic [TIME_W-1:0]     window_min_us;
	logic [TIME_W-1:0]     window_max_us;
	logic                  window_empty;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sliding_time_window_min_max_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_time_us (frame_time_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.average_us    (average_us),
		.window_min_us (window_min_us),
		.window_max_us (window_max_us),
		.window_empty  (window_empty),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the block: history row (slot 0 newest), average and registers.
	logic [TIME_W-1:0] hist_dur  [MAX_ENTRIES];
	logic [AGE_W-1:0]  hist_age  [MAX_ENTRIES];
	logic              hist_live [MAX_ENTRIES];
	logic [ACC_W-1:0]  ema_acc;
	logic [WGT_W-1:0]  gain_q16;
	logic [WIN_W-1:0]  window_us;

	logic [TIME_W-1:0] frames_to_send [$];
	frame_stats_t      stats_due [$];

	// Idling switches, changed only between phases while everything is drained.
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int errors = 0;

	// Mostly short gaps, now and then a long one that can span a whole item.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 10)
			return $urandom_range(0, 3);
		else if (r < 14)
			return $urandom_range(4, 20);
		return $urandom_range(21, 150);
	endfunction

	// One frame through the shadow: average update, push, ageing, expiry, min/max.
	function automatic frame_stats_t fold_frame(input logic [TIME_W-1:0] t);
		frame_stats_t r;
		logic [63:0]  mix;
		logic [AGE_W:0] aged;
		logic         found;
		int           i;
		found = 1'b0;
		r = '0;
		mix = 64'(ema_acc) * 64'(WEIGHT_ONE - gain_q16) + (64'(t) << FRAC_W) * 64'(gain_q16);
		ema_acc = mix[FRAC_W +: ACC_W];

		for (i = MAX_ENTRIES - 1; i > 0; i--) begin
			hist_dur[i]  = hist_dur[i-1];
			hist_age[i]  = hist_age[i-1];
			hist_live[i] = hist_live[i-1];
		end
		hist_dur[0]  = t;
		hist_age[0]  = '0;
		hist_live[0] = 1'b1;

		for (i = 0; i < MAX_ENTRIES; i++) begin
			if (hist_live[i]) begin
				aged = {1'b0, hist_age[i]} + (AGE_W+1)'(t);
				hist_age[i] = (aged > {1'b0, AGE_MAX}) ? AGE_MAX : aged[AGE_W-1:0];
				if ({1'b0, hist_age[i]} > (AGE_W+1)'(window_us)) begin
					hist_live[i] = 1'b0;
				end else if (!found) begin
					r.min_us = hist_dur[i];
					r.max_us = hist_dur[i];
					found = 1'b1;
				end else begin
					if (hist_dur[i] < r.min_us)
						r.min_us = hist_dur[i];
					if (hist_dur[i] > r.max_us)
						r.max_us = hist_dur[i];
				end
			end
		end

		// nothing survived: extremes echo the new frame
		if (!found) begin
			r.min_us = t;
			r.max_us = t;
		end
		r.avg_us    = ema_acc[FRAC_W +: TIME_W];
		r.none_live = ~found;
		return r;
	endfunction

	// Register write as the block sees it; a gain above one is clamped, other indexes dropped.
	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_AVERAGE_WEIGHT: begin
				gain_q16 = (data[WGT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE : data[WGT_W-1:0];
			end
			REG_WINDOW_LENGTH: begin
				window_us = data[WIN_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Sender: feeds queued frames; each transfer is folded into the shadow at once.
	int unsigned send_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			frame_time_us <= '0;
		end else begin
			if (in_valid && in_ready) begin
				stats_due.push_back(fold_frame(frame_time_us));
				send_hold = send_idle ? pick_gap() : 0;
			end
			if (!in_valid || in_ready) begin
				if (send_hold != 0) begin
					send_hold--;
					in_valid <= 1'b0;
				end else if (frames_to_send.size() != 0) begin
					in_valid      <= 1'b1;
					frame_time_us <= frames_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls; each result transfer is checked against the oldest prediction.
	int unsigned recv_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		frame_stats_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (stats_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual avg %0d min %0d max %0d",
						$time, average_us, window_min_us, window_max_us);
					errors++;
				end else begin
					want = stats_due.pop_front();
					check_field("average_us", want.avg_us, average_us);
					check_field("window_min_us", want.min_us, window_min_us);
					check_field("window_max_us", want.max_us, window_max_us);
					check_field("window_empty", TIME_W'(want.none_live), TIME_W'(window_empty));
				end
			end
			if (recv_hold == 0 && recv_idle && $urandom_range(0, 7) == 0)
				recv_hold = pick_gap();
			if (recv_hold != 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without a transfer on any channel ends the run.
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sliding_time_window_min_max_top_test: errors");
			$finish;
		end
	end

	// Sender holds off until every result is in, then the block gets time to go idle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (frames_to_send.size() != 0 || in_valid || stats_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_write(idx, data);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		int unsigned shift;
		int unsigned r;
		logic [TIME_W-1:0] dur_top;
		longint unsigned   win;
		logic [CFG_DATA_W-1:0] gain_word;

		// shadow follows the reset values of the block
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hist_dur[i]  = '0;
			hist_age[i]  = '0;
			hist_live[i] = 1'b0;
		end
		ema_acc   = '0;
		gain_q16  = WEIGHT_RESET;
		window_us = WINDOW_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings: lone frame beyond the window, equal frames, frame exactly at the window.
		frames_to_send = '{TIME_W'(0), TIME_TOP, TIME_W'(1), TIME_W'(500000), TIME_W'(500000),
			TIME_W'(499999), TIME_W'(1000000), TIME_W'(1000001)};
		wait_drained();

		// Gain word with every bit set clamps to one; zero window keeps only zero-length frames.
		write_reg(REG_AVERAGE_WEIGHT, DATA_TOP);
		write_reg(REG_WINDOW_LENGTH, '0);
		frames_to_send = '{TIME_W'(0), TIME_W'(0), TIME_W'(5), TIME_W'(0), TIME_TOP};
		wait_drained();

		// Zero gain freezes the average; widest window.
		write_reg(REG_AVERAGE_WEIGHT, '0);
		write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(WIN_TOP));
		frames_to_send = '{TIME_TOP, TIME_TOP, TIME_W'(1), TIME_W'(0), TIME_W'(12345)};
		wait_drained();

		// Writes to unused indexes must leave both registers alone.
		write_reg(CFG_IDX_W'(2), DATA_TOP);
		write_reg(CFG_IDX_W'(3), CFG_DATA_W'($urandom));
		write_reg(REG_AVERAGE_WEIGHT, CFG_DATA_W'(WEIGHT_ONE));
		write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
		write_reg(CFG_IDX_W'(3), '0);
		frames_to_send = '{TIME_W'(1), TIME_W'(2), TIME_W'(0), TIME_W'(1)};
		wait_drained();

		// Random phases: frame lengths scaled to the window so entries both expire and
		// pile up past the store depth.
		sent = 0;
		while (sent < RANDOM_FRAMES) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);

			r = $urandom_range(0, 9);
			case (r)
				0: gain_word = '0;
				1: gain_word = CFG_DATA_W'(WEIGHT_ONE);
				2: gain_word = CFG_DATA_W'($urandom_range(65537, 131071));
				3: gain_word = CFG_DATA_W'($urandom);
				default: gain_word = CFG_DATA_W'($urandom_range(0, 65536));
			endcase
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
			write_reg(REG_AVERAGE_WEIGHT, gain_word);

			shift   = $urandom_range(1, TIME_W);
			dur_top = TIME_W'((64'd1 << shift) - 1);
			r = $urandom_range(0, 9);
			if (r == 0)
				win = 0;
			else if (r == 1)
				win = WIN_TOP;
			else if (r == 2)
				win = $urandom & WIN_TOP;
			else
				win = longint'(dur_top) * $urandom_range(1, 80);
			if (win > WIN_TOP)
				win = WIN_TOP;
			write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(win));

			n = $urandom_range(60, 200);
			repeat (n) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					frames_to_send.push_back(TIME_W'($urandom));
				else if (r == 1)
					frames_to_send.push_back($urandom_range(0, 1) ? TIME_TOP : TIME_W'(0));
				else
					frames_to_send.push_back(TIME_W'($urandom_range(0, dur_top)));
			end
			sent += n;
			wait_drained();
		end

		if (stats_due.size() != 0) begin
			$display("%0t ns: %0d results missing, expected %0d more, actual 0", $time,
				stats_due.size(), stats_due.size());
			errors++;
		end
		if (errors == 0)
			$display("sliding_time_window_min_max_top_test: clean");
		else
			$display("sliding_time_window_min_max_top_test: errors");
		$finish;
	end

endmodule
